/* design/coordinate_key_dense_indexer_defines.svh */
// ----------------------------------------------------------------------------
// Coordinate key dense indexer assertion macros
// Shared property wrappers used by the indexer modules.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_KEY_DENSE_INDEXER_DEFINES_SVH
`define COORDINATE_KEY_DENSE_INDEXER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define CKDI_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define CKDI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* design/ckdi_pkg.sv */
// ----------------------------------------------------------------------------
// Coordinate key dense indexer package
// Sizes, hash constants and the command/status types shared by the modules.
// ----------------------------------------------------------------------------
package ckdi_pkg;

    // Table sizes (HASH_SLOTS is a power of two)
    localparam int HASH_SLOTS = 8192;
    localparam int MAX_KEYS   = 4096;
    localparam int MAX_PROBES = 16;
    localparam int KEY_SPLIT  = 32;

    // Field widths
    localparam int COORD_W = 32;
    localparam int COUNT_W = 32;
    localparam int KEY_W   = 64;
    localparam int INDEX_W = 12;
    localparam int TOTAL_W = 13;

    // Derived widths
    localparam int SLOT_W  = $clog2(HASH_SLOTS);
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int SIDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int PROBE_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

    // Hash: only product bits up to KEY_SPLIT + SLOT_W - 1 matter
    localparam int PROD_W    = KEY_SPLIT + SLOT_W;
    localparam int DIGIT_W   = 16;
    localparam int MUL_STEPS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);
    localparam int KSH_W     = DIGIT_W * MUL_STEPS;
    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    typedef logic [KEY_W-1:0] t_key;

    // Lookup outcome
    typedef enum logic [1:0] {
        RES_HIT,
        RES_NEW,
        RES_FULL
    } t_res;

    // One hash table slot
    typedef struct packed {
        logic              valid;
        logic [SIDX_W-1:0] idx;
        t_key              key;
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic hash_step;
        logic probe_next;
        logic finish;
        t_res kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic slot_valid;
        logic key_match;
        logic probe_last;
        logic keys_left;
        logic out_free;
    } t_sts;

endpackage

/* design/ckdi_if.sv */
// ----------------------------------------------------------------------------
// Coordinate key dense indexer channels
// Valid/ready record and result channels with source and sink modports.
// ----------------------------------------------------------------------------
interface ckdi_in_if import ckdi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COUNT_W-1:0] read_count;
    logic               last_record;

    modport source (output valid, output coord_x, output coord_y,
                    output read_count, output last_record, input ready);
    modport sink   (input valid, input coord_x, input coord_y,
                    input read_count, input last_record, output ready);
endinterface

interface ckdi_out_if import ckdi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] dense_index;
    logic [COUNT_W-1:0] count_out;
    logic               key_is_new;
    logic [KEY_W-1:0]   new_key;
    logic [TOTAL_W-1:0] unique_total;
    logic               table_full;
    logic               last_out;

    modport source (output valid, output dense_index, output count_out,
                    output key_is_new, output new_key, output unique_total,
                    output table_full, output last_out, input ready);
    modport sink   (input valid, input dense_index, input count_out,
                    input key_is_new, input new_key, input unique_total,
                    input table_full, input last_out, output ready);
endinterface

/* design/coordinate_key_dense_indexer.sv */
// A record is captured, hashed, probed (1..16 probes) and handed to the output register.
// A new record is taken only once the previous one has been handed to the output register.
// The probe loop runs on the single-port slot memory: one read and compare per probe,
// after a three-step 16-bit digit hash multiply.
// Reset: synchronous, active low; then a pass clears all 8192 slots with ready low.
// A finished result waits in the output register while the next record is taken.
// ----------------------------------------------------------------------------
// Coordinate key dense indexer
// Maps (x, y) coordinate keys to dense first-seen indexes through an
// open-addressed, linearly probed hash table.
// ----------------------------------------------------------------------------
module coordinate_key_dense_indexer import ckdi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ckdi_in_if.sink    i_rec,
    ckdi_out_if.source o_res
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // Sequencer
    ckdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rec.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table, hash and result path
    ckdi_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (i_rec),
        .o_res   (o_res),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    assign i_rec.ready = w_in_ready;

endmodule

/* design/ckdi_datapath.sv */
// ----------------------------------------------------------------------------
// Coordinate key dense indexer datapath
// Key capture, digit-serial hash, slot memory, probe compare, index counter
// and the result register.
// ----------------------------------------------------------------------------
`include "coordinate_key_dense_indexer_defines.svh"

module ckdi_datapath import ckdi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ckdi_in_if.sink           i_rec,
    ckdi_out_if.source        o_res,
    input  t_cmd              i_cmd,
    output t_sts              o_sts
);

    localparam logic [PROD_W-1:0] HASH_MULT_P = HASH_MULT[PROD_W-1:0];

    // Item registers
    t_key               r_key;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_last;

    // Hash and probe registers
    logic [KSH_W-1:0]   r_ksh;
    logic [PROD_W-1:0]  r_acc;
    logic [STEP_W-1:0]  r_dig;
    logic [PROBE_W-1:0] r_probe;

    // Table state
    t_slot              r_slot_mem [HASH_SLOTS];
    t_slot              r_rd;
    logic [SLOT_W-1:0]  r_clr;
    logic [CNT_W-1:0]   r_next_free;

    // Result register
    logic               r_ovalid;
    logic [INDEX_W-1:0] r_dense_index;
    logic [COUNT_W-1:0] r_count_out;
    logic               r_key_is_new;
    t_key               r_new_key;
    logic [TOTAL_W-1:0] r_unique_total;
    logic               r_table_full;
    logic               r_last_out;

    logic [DIGIT_W-1:0]        w_digit;
    logic [DIGIT_W+PROD_W-1:0] w_prod;
    logic [SLOT_W-1:0]         w_home;
    logic [SLOT_W-1:0]         w_addr;
    logic [SLOT_W-1:0]         w_mem_addr;
    logic                      w_mem_we;
    logic                      w_ins;
    t_slot                     w_mem_wd;

    // Hash digit product, most significant digit first
    assign w_digit = r_ksh[KSH_W-1 -: DIGIT_W];
    assign w_prod  = {{PROD_W{1'b0}}, w_digit} * {{DIGIT_W{1'b0}}, HASH_MULT_P};

    // Probe address: home slot plus probe offset, wrapping
    assign w_home = r_acc[PROD_W-1 -: SLOT_W];
    assign w_addr = w_home + SLOT_W'(r_probe);

    // Memory port: clearing sweep or insert of a new key
    assign w_ins      = i_cmd.finish && (i_cmd.kind == RES_NEW);
    assign w_mem_we   = i_cmd.clr_wr || w_ins;
    assign w_mem_addr = i_cmd.clr_wr ? r_clr : w_addr;
    always_comb begin
        w_mem_wd = '0;
        if (!i_cmd.clr_wr) begin
            w_mem_wd.valid = 1'b1;
            w_mem_wd.idx   = SIDX_W'(r_next_free);
            w_mem_wd.key   = r_key;
        end
    end

    // Slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_slot_mem[w_mem_addr] <= w_mem_wd;
        end
        r_rd <= r_slot_mem[w_mem_addr];
    end

    // Status toward the controller
    assign o_sts.clr_done   = (r_clr == SLOT_W'(HASH_SLOTS - 1));
    assign o_sts.hash_done  = (r_dig == STEP_W'(MUL_STEPS - 1));
    assign o_sts.slot_valid = r_rd.valid;
    assign o_sts.key_match  = (r_rd.key == r_key);
    assign o_sts.probe_last = (r_probe == PROBE_W'(MAX_PROBES - 1));
    assign o_sts.keys_left  = (r_next_free < CNT_W'(MAX_KEYS));
    assign o_sts.out_free   = !r_ovalid || o_res.ready;

    // Control state: clear pointer, key counter, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_next_free <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_ins) begin
                r_next_free <= r_next_free + 1'b1;
            end
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Capture the record, run the hash, advance the probe
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= {i_rec.coord_x, i_rec.coord_y};
            r_cnt   <= i_rec.read_count;
            r_last  <= i_rec.last_record;
            r_ksh   <= KSH_W'({i_rec.coord_x, i_rec.coord_y});
            r_acc   <= '0;
            r_dig   <= '0;
            r_probe <= '0;
        end
        if (i_cmd.hash_step) begin
            r_acc <= (r_acc << DIGIT_W) + w_prod[PROD_W-1:0];
            r_ksh <= r_ksh << DIGIT_W;
            r_dig <= r_dig + 1'b1;
        end
        if (i_cmd.probe_next) begin
            r_probe <= r_probe + 1'b1;
        end
    end

    // Load the result register on finish
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_count_out <= r_cnt;
            r_new_key   <= r_key;
            r_last_out  <= r_last;
            case (i_cmd.kind)
                RES_HIT: begin
                    r_dense_index  <= INDEX_W'(r_rd.idx);
                    r_key_is_new   <= 1'b0;
                    r_table_full   <= 1'b0;
                    r_unique_total <= TOTAL_W'(r_next_free);
                end
                RES_NEW: begin
                    r_dense_index  <= INDEX_W'(r_next_free);
                    r_key_is_new   <= 1'b1;
                    r_table_full   <= 1'b0;
                    r_unique_total <= TOTAL_W'(r_next_free + 1'b1);
                end
                default: begin
                    r_dense_index  <= '0;
                    r_key_is_new   <= 1'b0;
                    r_table_full   <= 1'b1;
                    r_unique_total <= TOTAL_W'(r_next_free);
                end
            endcase
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.dense_index  = r_dense_index;
    assign o_res.count_out    = r_count_out;
    assign o_res.key_is_new   = r_key_is_new;
    assign o_res.new_key      = r_new_key;
    assign o_res.unique_total = r_unique_total;
    assign o_res.table_full   = r_table_full;
    assign o_res.last_out     = r_last_out;

    // Checks
    `CKDI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_next_free <= CNT_W'(MAX_KEYS))
    `CKDI_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, w_ins, r_next_free == $past(r_next_free) + 1'b1)
    `CKDI_ASSERT_NOW(a_new_not_full, i_clk, i_rst_n, r_ovalid, !(r_key_is_new && r_table_full))

endmodule

/* design/ckdi_ctrl.sv */
// ----------------------------------------------------------------------------
// Coordinate key dense indexer controller
// Sequences clearing, hashing, probing and result hand-off.
// ----------------------------------------------------------------------------
`include "coordinate_key_dense_indexer_defines.svh"

module ckdi_ctrl import ckdi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    t_res   r_kind, n_kind;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_HASH;
                end
            end
            ST_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!i_sts.slot_valid) begin
                    n_kind  = i_sts.keys_left ? RES_NEW : RES_FULL;
                    n_state = ST_DONE;
                end else if (i_sts.key_match) begin
                    n_kind  = RES_HIT;
                    n_state = ST_DONE;
                end else if (i_sts.probe_last) begin
                    n_kind  = RES_FULL;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = ST_READ;
                end
            end
            ST_DONE: begin
                // Hand the result over once the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and the lookup outcome
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_kind  <= RES_HIT;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Checks
    `CKDI_ASSERT_NOW(a_finish_free, i_clk, i_rst_n, o_cmd.finish, i_sts.out_free)
    `CKDI_ASSERT_NOW(a_probe_limit, i_clk, i_rst_n, o_cmd.probe_next, !i_sts.probe_last)
    `CKDI_ASSERT_NOW(a_insert_room, i_clk, i_rst_n, o_cmd.finish && (r_kind == RES_NEW), i_sts.keys_left && !i_sts.slot_valid)

endmodule
